>>> src/wdg_pkg.sv
// shared constants, types and control structs for the waveform digest block
// no dependencies; compiled first
package wdg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 20;
    localparam int PTS_W      = 21;
    localparam int BINS_W     = 13;
    localparam int BIN_IDX_W  = 12;
    localparam int CHANS_W    = 4;
    localparam int CHAN_IDX_W = 3;
    localparam int SUM_W      = 37;
    localparam int CNT_W      = 21;
    localparam int PROD_W     = 34;
    localparam int MEAN_W     = 24;
    localparam int DIV_W      = 45;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [PTS_W-1:0]   MAX_POINTS   = PTS_W'(1048576);
    localparam logic [BINS_W-1:0]  MAX_BINS     = BINS_W'(4096);
    localparam logic [CHANS_W-1:0] MAX_CHANNELS = CHANS_W'(8);

    localparam logic [PTS_W-1:0]   RST_POINTS   = PTS_W'(65536);
    localparam logic [BINS_W-1:0]  RST_BINS     = BINS_W'(1024);
    localparam logic [CHANS_W-1:0] RST_CHANNELS = CHANS_W'(4);

    localparam logic [CFG_IDX_W-1:0] REG_POINTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BINS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

    localparam logic KIND_BIN   = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_CHECK,
        ST_BIN_DIV,
        ST_BIN_PUT,
        ST_MEAN_DIV,
        ST_MEAN_PUT
    } wdg_state_t;

    typedef struct packed {
        logic in_ready;
        logic take_sample;
        logic calc;
        logic start_bin_div;
        logic start_mean_div;
        logic put_bin;
        logic put_stats;
        logic advance;
    } wdg_cmd_t;

    typedef struct packed {
        logic close;
        logic chan_end;
        logic div_done;
        logic out_free;
    } wdg_status_t;

endpackage

>>> src/wdg_sample_if.sv
// input channel: one signed sample word per handshake
// depends on wdg_pkg
interface wdg_sample_if;
    import wdg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

>>> src/wdg_result_if.sv
// output channel: one bin or channel statistics word per handshake
// depends on wdg_pkg
interface wdg_result_if;
    import wdg_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [CHAN_IDX_W-1:0]        channel;
    logic [BIN_IDX_W-1:0]         bin_number;
    logic signed [SAMPLE_W-1:0]   bin_average;
    logic signed [SAMPLE_W-1:0]   channel_min;
    logic signed [SAMPLE_W-1:0]   channel_max;
    logic signed [MEAN_W-1:0]     channel_mean;
    logic signed [SAMPLE_W-1:0]   overall_min;
    logic signed [SAMPLE_W-1:0]   overall_max;
    logic                         last;

    modport source (output valid, output kind, output channel, output bin_number,
                    output bin_average, output channel_min, output channel_max,
                    output channel_mean, output overall_min, output overall_max,
                    output last, input ready);
    modport sink (input valid, input kind, input channel, input bin_number,
                  input bin_average, input channel_min, input channel_max,
                  input channel_mean, input overall_min, input overall_max,
                  input last, output ready);
endinterface

>>> src/wdg_div.sv
// iterative signed-by-unsigned restoring divider, one quotient bit per cycle
// depends on wdg_pkg
module wdg_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [wdg_pkg::DIV_W-1:0] dividend,
    input  logic [wdg_pkg::CNT_W-1:0]        divisor,
    output logic                             done,
    output logic signed [wdg_pkg::DIV_W-1:0] quotient
);
    import wdg_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [DIV_W-1:0]     mag_reg;
    logic [CNT_W-1:0]     den_reg;
    logic [CNT_W:0]       rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W:0]       rem_shift;
    logic                 fits;

    assign rem_shift = {rem_reg[CNT_W-1:0], mag_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitude register shifts out dividend bits and takes in quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DIV_W-1];
            mag_reg <= dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
endmodule

>>> src/wdg_ctrl.sv
// sequencing state machine: accept, update, close bin, close channel
// depends on wdg_pkg
module wdg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  wdg_pkg::wdg_status_t status,
    output wdg_pkg::wdg_cmd_t    cmd
);
    import wdg_pkg::*;

    wdg_state_t state_reg;
    wdg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_sample = 1'b1;
                    state_next      = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.close)
                begin
                    cmd.start_bin_div = 1'b1;
                    state_next        = ST_BIN_DIV;
                end
                else if (status.chan_end)
                begin
                    cmd.start_mean_div = 1'b1;
                    state_next         = ST_MEAN_DIV;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_BIN_DIV:
            begin
                if (status.div_done)
                    state_next = ST_BIN_PUT;
            end
            ST_BIN_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.put_bin = 1'b1;
                    if (status.chan_end)
                    begin
                        cmd.start_mean_div = 1'b1;
                        state_next         = ST_MEAN_DIV;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_MEAN_DIV:
            begin
                if (status.div_done)
                    state_next = ST_MEAN_PUT;
            end
            ST_MEAN_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.put_stats = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

>>> src/wdg_dp.sv
// datapath: config registers, counters, sums, extremes, divider, output register
// depends on wdg_pkg, wdg_result_if and wdg_div
module wdg_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [wdg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wdg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [wdg_pkg::SAMPLE_W-1:0] sample,
    input  wdg_pkg::wdg_cmd_t                  cmd,
    output wdg_pkg::wdg_status_t               status,
    wdg_result_if.source                       results
);
    import wdg_pkg::*;

    logic [PTS_W-1:0]   points_reg;
    logic [BINS_W-1:0]  bins_reg;
    logic [CHANS_W-1:0] chans_reg;

    logic [PTS_W-1:0]   p_eff;
    logic [BINS_W-1:0]  b_lim;
    logic [BINS_W-1:0]  b_eff;
    logic [CHANS_W-1:0] c_eff;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic [POS_W-1:0]           pos_reg;
    logic [BIN_IDX_W-1:0]       bin_pos_reg;
    logic signed [SUM_W-1:0]    bin_sum_reg;
    logic [CNT_W-1:0]           bin_cnt_reg;
    logic signed [SUM_W-1:0]    chan_sum_reg;
    logic signed [SAMPLE_W-1:0] chan_low_reg;
    logic signed [SAMPLE_W-1:0] chan_high_reg;
    logic [CHAN_IDX_W-1:0]      chan_num_reg;
    logic signed [SAMPLE_W-1:0] frame_low_reg;
    logic signed [SAMPLE_W-1:0] frame_high_reg;
    logic [PROD_W-1:0]          prod_i_reg;
    logic [PROD_W-1:0]          prod_j_reg;

    logic [PTS_W-1:0]     i1;
    logic [BINS_W-1:0]    j1;
    logic                 shared;
    logic [CHANS_W-1:0]   chan_num1;

    logic                       div_start;
    logic signed [DIV_W-1:0]    div_dividend;
    logic [CNT_W-1:0]           div_divisor;
    logic                       div_done;
    logic signed [DIV_W-1:0]    div_quot;

    logic signed [SAMPLE_W-1:0] bin_avg;
    logic signed [MEAN_W-1:0]   mean_sat;
    logic signed [SAMPLE_W-1:0] frame_low_next;
    logic signed [SAMPLE_W-1:0] frame_high_next;

    logic                       out_valid_reg;
    logic                       out_kind_reg;
    logic [CHAN_IDX_W-1:0]      out_chan_reg;
    logic [BIN_IDX_W-1:0]       out_bin_reg;
    logic signed [SAMPLE_W-1:0] out_avg_reg;
    logic signed [SAMPLE_W-1:0] out_cmin_reg;
    logic signed [SAMPLE_W-1:0] out_cmax_reg;
    logic signed [MEAN_W-1:0]   out_mean_reg;
    logic signed [SAMPLE_W-1:0] out_omin_reg;
    logic signed [SAMPLE_W-1:0] out_omax_reg;
    logic                       out_last_reg;

    // register values limited to the supported ranges
    always_comb
    begin
        p_eff = points_reg;
        if (points_reg == '0)
            p_eff = PTS_W'(1);
        else if (points_reg > MAX_POINTS)
            p_eff = MAX_POINTS;

        b_lim = bins_reg;
        if (bins_reg == '0)
            b_lim = BINS_W'(1);
        else if (bins_reg > MAX_BINS)
            b_lim = MAX_BINS;
        b_eff = ({{(PTS_W-BINS_W){1'b0}}, b_lim} > p_eff) ? BINS_W'(p_eff) : b_lim;

        c_eff = chans_reg;
        if (chans_reg == '0)
            c_eff = CHANS_W'(1);
        else if (chans_reg > MAX_CHANNELS)
            c_eff = MAX_CHANNELS;
    end

    assign i1        = {1'b0, pos_reg} + 1'b1;
    assign j1        = {1'b0, bin_pos_reg} + 1'b1;
    assign shared    = prod_i_reg > prod_j_reg;
    assign chan_num1 = {1'b0, chan_num_reg} + 1'b1;

    assign status.close    = prod_i_reg >= prod_j_reg;
    assign status.chan_end = i1 >= p_eff;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= RST_POINTS;
            bins_reg   <= RST_BINS;
            chans_reg  <= RST_CHANNELS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_POINTS:   points_reg <= cfg_data[PTS_W-1:0];
                REG_BINS:     bins_reg   <= cfg_data[BINS_W-1:0];
                REG_CHANNELS: chans_reg  <= cfg_data[CHANS_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            bin_pos_reg    <= '0;
            bin_sum_reg    <= '0;
            bin_cnt_reg    <= '0;
            chan_sum_reg   <= '0;
            chan_low_reg   <= '0;
            chan_high_reg  <= '0;
            chan_num_reg   <= '0;
            frame_low_reg  <= '0;
            frame_high_reg <= '0;
        end
        else
        begin
            if (cmd.calc)
            begin
                if (pos_reg == '0)
                begin
                    chan_low_reg  <= x_reg;
                    chan_high_reg <= x_reg;
                end
                else
                begin
                    if (x_reg < chan_low_reg)
                        chan_low_reg <= x_reg;
                    if (x_reg > chan_high_reg)
                        chan_high_reg <= x_reg;
                end
                chan_sum_reg <= chan_sum_reg + SUM_W'(x_reg);
                bin_sum_reg  <= bin_sum_reg + SUM_W'(x_reg);
                bin_cnt_reg  <= bin_cnt_reg + 1'b1;
            end
            if (cmd.put_bin)
            begin
                // a sample that straddles the boundary also opens the next bin
                bin_sum_reg <= shared ? SUM_W'(x_reg) : '0;
                bin_cnt_reg <= shared ? CNT_W'(1) : '0;
                bin_pos_reg <= j1[BIN_IDX_W-1:0];
            end
            if (cmd.advance)
                pos_reg <= i1[POS_W-1:0];
            if (cmd.put_stats)
            begin
                frame_low_reg  <= frame_low_next;
                frame_high_reg <= frame_high_next;
                pos_reg        <= '0;
                bin_pos_reg    <= '0;
                bin_sum_reg    <= '0;
                bin_cnt_reg    <= '0;
                chan_sum_reg   <= '0;
                chan_num_reg   <= (chan_num1 >= c_eff) ? '0 : chan_num1[CHAN_IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
            x_reg <= sample;
        if (cmd.calc)
        begin
            prod_i_reg <= PROD_W'(i1) * PROD_W'(b_eff);
            prod_j_reg <= PROD_W'(j1) * PROD_W'(p_eff);
        end
    end

    assign div_start    = cmd.start_bin_div | cmd.start_mean_div;
    assign div_dividend = cmd.start_mean_div ? DIV_W'({chan_sum_reg, 8'h00})
                                             : DIV_W'(bin_sum_reg);
    assign div_divisor  = cmd.start_mean_div ? CNT_W'(p_eff) : bin_cnt_reg;

    wdg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        bin_avg = (bin_cnt_reg == '0) ? '0 : div_quot[SAMPLE_W-1:0];

        if (div_quot > DIV_W'(8388607))
            mean_sat = MEAN_W'(8388607);
        else if (div_quot < -DIV_W'(8388608))
            mean_sat = MEAN_W'(-8388608);
        else
            mean_sat = div_quot[MEAN_W-1:0];

        if (chan_num_reg == '0)
        begin
            frame_low_next  = chan_low_reg;
            frame_high_next = chan_high_reg;
        end
        else
        begin
            frame_low_next  = (chan_low_reg < frame_low_reg) ? chan_low_reg : frame_low_reg;
            frame_high_next = (chan_high_reg > frame_high_reg) ? chan_high_reg
                                                               : frame_high_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.put_bin | cmd.put_stats)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_bin)
        begin
            out_kind_reg <= KIND_BIN;
            out_chan_reg <= chan_num_reg;
            out_bin_reg  <= bin_pos_reg;
            out_avg_reg  <= bin_avg;
            out_cmin_reg <= '0;
            out_cmax_reg <= '0;
            out_mean_reg <= '0;
            out_omin_reg <= '0;
            out_omax_reg <= '0;
            out_last_reg <= !status.chan_end;
        end
        else if (cmd.put_stats)
        begin
            out_kind_reg <= KIND_STATS;
            out_chan_reg <= chan_num_reg;
            out_bin_reg  <= '0;
            out_avg_reg  <= '0;
            out_cmin_reg <= chan_low_reg;
            out_cmax_reg <= chan_high_reg;
            out_mean_reg <= mean_sat;
            out_omin_reg <= frame_low_next;
            out_omax_reg <= frame_high_next;
            out_last_reg <= 1'b1;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.kind         = out_kind_reg;
    assign results.channel      = out_chan_reg;
    assign results.bin_number   = out_bin_reg;
    assign results.bin_average  = out_avg_reg;
    assign results.channel_min  = out_cmin_reg;
    assign results.channel_max  = out_cmax_reg;
    assign results.channel_mean = out_mean_reg;
    assign results.overall_min  = out_omin_reg;
    assign results.overall_max  = out_omax_reg;
    assign results.last         = out_last_reg;
endmodule

>>> src/waveform_digest_and_stats.sv
// Boxcar decimator with channel min/max/mean and frame min/max. One sample is
// taken at a time. A sample that closes no bin and ends no channel passes
// through the idle, calc and check states. A bin close and a channel end each
// add a run of the shared 45-step restoring divider (one quotient bit per cycle)
// that forms bin averages and channel means; a result waiting in the output
// register delays the next result load until it is taken. Configuration may be
// written only while no sample is in progress.
// depends on wdg_pkg, wdg_sample_if, wdg_result_if, wdg_ctrl, wdg_dp
module waveform_digest_and_stats (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [wdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wdg_pkg::CFG_DATA_W-1:0] cfg_data,
    wdg_sample_if.sink                     samples,
    wdg_result_if.source                   results
);
    import wdg_pkg::*;

    wdg_cmd_t    cmd;
    wdg_status_t status;

    wdg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .status   (status),
        .cmd      (cmd)
    );

    wdg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (samples.sample),
        .cmd       (cmd),
        .status    (status),
        .results   (results)
    );

    assign samples.ready = cmd.in_ready;

    // one word in flight: no second accept right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("sample accepted while previous word in progress");

    // a result is only loaded into an empty output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_bin || cmd.put_stats) |-> !results.valid)
        else $error("output register overwritten");

    // statistics always end the step
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.kind == KIND_STATS) |-> results.last)
        else $error("statistics word without last");

    // bin words carry no statistics
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.kind == KIND_BIN) |->
            (results.channel_min == '0 && results.overall_max == '0))
        else $error("bin word with statistics fields set");
endmodule

>>> tb/wdg_checker.sv
`timescale 1ns / 100ps
// checker for the waveform digest block: watches the config port and both channels,
// predicts bin and channel statistics words and compares them in order
// depends on wdg_pkg, wdg_sample_if, wdg_result_if
module wdg_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [wdg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wdg_pkg::CFG_DATA_W-1:0] cfg_data,
    wdg_sample_if                          samples,
    wdg_result_if                          results,
    output int                             mismatches,
    output int                             words_pending,
    output int                             bins_seen,
    output int                             stats_seen
);
    import wdg_pkg::*;

    typedef struct {
        logic                       kind;
        logic [CHAN_IDX_W-1:0]      channel;
        logic [BIN_IDX_W-1:0]       bin_number;
        logic signed [SAMPLE_W-1:0] bin_average;
        logic signed [SAMPLE_W-1:0] channel_min;
        logic signed [SAMPLE_W-1:0] channel_max;
        logic signed [MEAN_W-1:0]   channel_mean;
        logic signed [SAMPLE_W-1:0] overall_min;
        logic signed [SAMPLE_W-1:0] overall_max;
        logic                       last;
    } digest_word_t;

    digest_word_t expected_words[$];

    // predictor copy of configuration and state
    longint cfg_points, cfg_bins, cfg_chans;
    longint pos, bin_idx, bin_acc, bin_cnt, chan_acc, chan_lo, chan_hi, chan_idx;
    longint frame_lo, frame_hi;

    assign words_pending = expected_words.size();

    task automatic predict_digest(input longint x);
        longint p, b, c, avg, mean;
        bit shared, closes;
        digest_word_t bw, sw;
        begin
            p = cfg_points;
            b = cfg_bins;
            c = cfg_chans;
            if (p < 1) p = 1;
            if (p > longint'(MAX_POINTS)) p = longint'(MAX_POINTS);
            if (b < 1) b = 1;
            if (b > longint'(MAX_BINS)) b = longint'(MAX_BINS);
            if (b > p) b = p;
            if (c < 1) c = 1;
            if (c > longint'(MAX_CHANNELS)) c = longint'(MAX_CHANNELS);

            if (pos == 0)
            begin
                chan_lo = x;
                chan_hi = x;
            end
            else
            begin
                if (x < chan_lo) chan_lo = x;
                if (x > chan_hi) chan_hi = x;
            end
            chan_acc += x;
            bin_acc += x;
            bin_cnt++;

            bw = '{default: '0};
            closes = ((pos + 1) * b >= (bin_idx + 1) * p);
            if (closes)
            begin
                avg = (bin_cnt != 0) ? bin_acc / bin_cnt : 0;
                shared = ((pos + 1) * b > (bin_idx + 1) * p);
                bw.kind = KIND_BIN;
                bw.channel = chan_idx[CHAN_IDX_W-1:0];
                bw.bin_number = bin_idx[BIN_IDX_W-1:0];
                bw.bin_average = avg[SAMPLE_W-1:0];
                bin_acc = shared ? x : 0;
                bin_cnt = shared ? 1 : 0;
                bin_idx = (bin_idx + 1) & 12'hfff;
            end

            if (pos + 1 >= p)
            begin
                mean = (chan_acc * 256) / p;
                if (mean > 8388607) mean = 8388607;
                if (mean < -8388608) mean = -8388608;
                if (chan_idx == 0)
                begin
                    frame_lo = chan_lo;
                    frame_hi = chan_hi;
                end
                else
                begin
                    if (chan_lo < frame_lo) frame_lo = chan_lo;
                    if (chan_hi > frame_hi) frame_hi = chan_hi;
                end
                sw = '{default: '0};
                sw.kind = KIND_STATS;
                sw.channel = chan_idx[CHAN_IDX_W-1:0];
                sw.channel_min = chan_lo[SAMPLE_W-1:0];
                sw.channel_max = chan_hi[SAMPLE_W-1:0];
                sw.channel_mean = mean[MEAN_W-1:0];
                sw.overall_min = frame_lo[SAMPLE_W-1:0];
                sw.overall_max = frame_hi[SAMPLE_W-1:0];
                sw.last = 1'b1;
                if (closes)
                    expected_words.push_back(bw);
                expected_words.push_back(sw);
                pos = 0;
                bin_idx = 0;
                bin_acc = 0;
                bin_cnt = 0;
                chan_acc = 0;
                chan_idx = (chan_idx + 1 >= c) ? 0 : ((chan_idx + 1) & 7);
            end
            else
            begin
                pos = (pos + 1) & 20'hfffff;
                if (closes)
                begin
                    bw.last = 1'b1;
                    expected_words.push_back(bw);
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input longint exp_v, input longint act_v);
        begin
            if (mismatches < 10)
                $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $time);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t w;
        if (!rst_n)
        begin
            cfg_points = longint'(RST_POINTS);
            cfg_bins = longint'(RST_BINS);
            cfg_chans = longint'(RST_CHANNELS);
            pos = 0; bin_idx = 0; bin_acc = 0; bin_cnt = 0; chan_acc = 0;
            chan_lo = 0; chan_hi = 0; chan_idx = 0; frame_lo = 0; frame_hi = 0;
            expected_words.delete();
            mismatches = 0;
            bins_seen = 0;
            stats_seen = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (expected_words.size() == 0)
                    flag_mismatch("unexpected word, kind", -1, results.kind);
                else
                begin
                    w = expected_words.pop_front();
                    if (results.kind !== w.kind)
                        flag_mismatch("kind", w.kind, results.kind);
                    if (results.channel !== w.channel)
                        flag_mismatch("channel", w.channel, results.channel);
                    if (results.bin_number !== w.bin_number)
                        flag_mismatch("bin_number", w.bin_number, results.bin_number);
                    if (results.bin_average !== w.bin_average)
                        flag_mismatch("bin_average", w.bin_average, results.bin_average);
                    if (results.channel_min !== w.channel_min)
                        flag_mismatch("channel_min", w.channel_min, results.channel_min);
                    if (results.channel_max !== w.channel_max)
                        flag_mismatch("channel_max", w.channel_max, results.channel_max);
                    if (results.channel_mean !== w.channel_mean)
                        flag_mismatch("channel_mean", w.channel_mean, results.channel_mean);
                    if (results.overall_min !== w.overall_min)
                        flag_mismatch("overall_min", w.overall_min, results.overall_min);
                    if (results.overall_max !== w.overall_max)
                        flag_mismatch("overall_max", w.overall_max, results.overall_max);
                    if (results.last !== w.last)
                        flag_mismatch("last", w.last, results.last);
                    if (w.kind == KIND_BIN)
                        bins_seen++;
                    else
                        stats_seen++;
                end
            end
            if (samples.valid && samples.ready)
                predict_digest(longint'(samples.sample));
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_POINTS:   cfg_points = longint'(cfg_data[PTS_W-1:0]);
                    REG_BINS:     cfg_bins = longint'(cfg_data[BINS_W-1:0]);
                    REG_CHANNELS: cfg_chans = longint'(cfg_data[CHANS_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> tb/tb_waveform_digest_and_stats.sv
`timescale 1ns / 100ps
// top of the waveform digest testbench: clock, reset, config phases and sample
// stimulus with bursty sender and stalling receiver; verdict from wdg_checker
// depends on wdg_pkg, wdg_sample_if, wdg_result_if, waveform_digest_and_stats, wdg_checker
module tb_waveform_digest_and_stats;
    import wdg_pkg::*;

    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_WAIT     = 150;
    localparam int TARGET_SAMPLES = 580;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wdg_sample_if samples ();
    wdg_result_if results ();

    int mismatches, words_pending, bins_seen, stats_seen;
    int samples_sent;
    int burst_left;
    bit gaps_on;
    int hold_requests, holds_served, hold_left, stall_mode, mode_left;
    int idle_cycles;

    waveform_digest_and_stats dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples.sink),
        .results   (results.source)
    );

    wdg_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .samples       (samples),
        .results       (results),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .bins_seen     (bins_seen),
        .stats_seen    (stats_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: switches among random stall patterns, plus long hold-offs on request
    initial
    begin
        results.ready = 1'b0;
        holds_served = 0;
        hold_left = 0;
        stall_mode = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = 400;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: results.ready <= 1'b1;
                    1: results.ready <= ($urandom_range(0, 9) < 7);
                    2: results.ready <= ($urandom_range(0, 9) < 2);
                    default: results.ready <= ~results.ready;
                endcase
        end
    end

    // no handshake on either side for too long ends the run
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= value[CFG_DATA_W-1:0];
            @(negedge clk);
            cfg_write <= 1'b0;
        end
    endtask

    task automatic configure(input longint p, input longint b, input longint c);
        begin
            write_reg(REG_POINTS, p);
            write_reg(REG_BINS, b);
            write_reg(REG_CHANNELS, c);
        end
    endtask

    // wait until every predicted word has been received, then let the block settle
    task automatic drain;
        begin
            while (words_pending != 0)
                @(negedge clk);
            repeat (DRAIN_WAIT) @(negedge clk);
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                gap = gaps_on ? $urandom_range(0, 8) : 0;
                if (gap > 0)
                begin
                    samples.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            samples.valid <= 1'b1;
            samples.sample <= x;
            @(posedge clk);
            while (!samples.ready)
                @(posedge clk);
            samples_sent++;
            @(negedge clk);
        end
    endtask

    task automatic end_burst;
        begin
            samples.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        longint p, b, c, n;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.sample = '0;
        samples_sent = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_requests = 0;
        idle_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset configuration: extremes stay inside the first channel
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        end_burst();
        drain();

        // one point, one bin: every sample closes a bin and a channel
        configure(1, 1, 1);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        end_burst();
        drain();

        // shared boundary sample between bins
        configure(3, 2, 2);
        repeat (6) send_sample(pick_sample());
        end_burst();
        drain();

        // zero registers act as one, bins above points are limited
        configure(0, 0, 0);
        repeat (2) send_sample(pick_sample());
        end_burst();
        drain();
        configure(2, 4096, 8);
        repeat (4) send_sample(pick_sample());
        end_burst();
        drain();

        // over-range registers, then a change mid-channel ends it early
        configure(2097151, 8191, 15);
        repeat (4) send_sample(pick_sample());
        end_burst();
        drain();
        configure(1048576, 4096, 8);
        repeat (3) send_sample(pick_sample());
        end_burst();
        drain();
        configure(2, 1, 15);
        repeat (3) send_sample(pick_sample());
        end_burst();
        drain();

        // random phases, mostly short channels; one phase with a long receiver hold-off
        while (samples_sent < TARGET_SAMPLES)
        begin
            p = $urandom_range(1, 32);
            case ($urandom_range(0, 9))
                0: b = 0;
                1: b = p + $urandom_range(1, 8);
                2: b = p;
                default: b = $urandom_range(1, p);
            endcase
            c = $urandom_range(0, 15);
            if ($urandom_range(0, 15) == 0)
                p = 0;
            configure(p, b, c);
            gaps_on = ($urandom_range(0, 3) != 0);
            n = (p == 0 ? 1 : p) * $urandom_range(1, 4);
            if ($urandom_range(0, 4) == 0)
                n = n + $urandom_range(0, 5);
            if (hold_requests == 0 && samples_sent > 200)
                hold_requests++;
            repeat (n) send_sample(pick_sample());
            end_burst();
            drain();
        end

        $display("tb: %0d samples sent, %0d bin words and %0d statistics words checked",
                 samples_sent, bins_seen, stats_seen);
        $display("tb: configs covered zero, over-range and mid-channel changes");
        if (mismatches == 0 && words_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/wdg_pkg.sv
src/wdg_sample_if.sv
src/wdg_result_if.sv
src/wdg_div.sv
src/wdg_ctrl.sv
src/wdg_dp.sv
src/waveform_digest_and_stats.sv
tb/wdg_checker.sv
tb/tb_waveform_digest_and_stats.sv
